// ===== hw/rtl/rsfs_pkg.sv =====
// Shared types and constants for the rebar stress-from-strain pipeline.
`timescale 1ns / 1ps
`default_nettype none
package rsfs_pkg;

  localparam logic [2:0] REGION_ZERO    = 3'd0;
  localparam logic [2:0] REGION_ELASTIC = 3'd1;
  localparam logic [2:0] REGION_PLATEAU = 3'd2;
  localparam logic [2:0] REGION_HARDEN  = 3'd3;
  localparam logic [2:0] REGION_FAILED  = 3'd4;

  localparam logic [2:0] REG_MODULUS   = 3'd0;
  localparam logic [2:0] REG_YIELD     = 3'd1;
  localparam logic [2:0] REG_PLATEAU   = 3'd2;
  localparam logic [2:0] REG_ULT_STR   = 3'd3;
  localparam logic [2:0] REG_ULT_EPS   = 3'd4;
  localparam logic [2:0] REG_FAIL_EPS  = 3'd5;
  localparam logic [2:0] REG_FACTORS   = 3'd6;
  localparam logic [2:0] REG_OPTIONS   = 3'd7;

  localparam logic [31:0] FACTORS_RESET = 32'h1000_1000;
  localparam logic [1:0]  OPTIONS_RESET = 2'b01;
  localparam logic [15:0] FACTOR_UNITY  = 16'h1000;

  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = 8;

  typedef struct packed {
    logic        neg;
    logic [2:0]  region;
    logic        yielded;
    logic        at_max;
    logic [35:0] base_mag;
    logic [31:0] dl;
    logic [31:0] fu;
    logic        fu_ge;
    logic        q_hi;
    logic [31:0] rem;
    logic [31:0] d;
    logic [31:0] quo;
  } pipe_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rebar_stress_from_strain_core.sv =====
// Top level: configuration registers and the stress-from-strain pipeline.
//
//  channel   signals                                      handshake
//  input     start, strain[31:0]                          start && !busy
//  config    wr_en, wr_index[2:0], wr_data[63:0]          wr_en
//  result    done, stress, region, yielded, at_maximum    done, one cycle
//
// One word enters per cycle; busy is always low. Each result passes through 3 front
// stages, 8 divider stages of 4 restoring steps for the hardening ratio, and 5 back
// stages (two parabola multiplies, sum and factor select, factor multiply, saturation).
// Reset clears the valid bits and loads the register defaults. No stalls exist.
`timescale 1ns / 1ps
`default_nettype none
module rebar_stress_from_strain_core
  import rsfs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] strain,
  input  wire logic        wr_en,
  input  wire logic [2:0]  wr_index,
  input  wire logic [63:0] wr_data,
  output logic             done,
  output logic [31:0]      stress,
  output logic [2:0]       region,
  output logic             yielded,
  output logic             at_maximum
);

  logic [63:0] modulus_pair, yield_stress_pair, plateau_strain_pair;
  logic [63:0] ultimate_stress_pair, ultimate_strain_pair, failure_strain_pair;
  logic [31:0] increase_factors;
  logic [1:0]  option_flags;

  logic  dv [DIV_STAGES+1];
  pipe_t di [DIV_STAGES+1];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_pair         <= 64'd0;
      yield_stress_pair    <= 64'd0;
      plateau_strain_pair  <= 64'd0;
      ultimate_stress_pair <= 64'd0;
      ultimate_strain_pair <= 64'd0;
      failure_strain_pair  <= 64'd0;
      increase_factors     <= FACTORS_RESET;
      option_flags         <= OPTIONS_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_MODULUS:  modulus_pair         <= wr_data;
        REG_YIELD:    yield_stress_pair    <= wr_data;
        REG_PLATEAU:  plateau_strain_pair  <= wr_data;
        REG_ULT_STR:  ultimate_stress_pair <= wr_data;
        REG_ULT_EPS:  ultimate_strain_pair <= wr_data;
        REG_FAIL_EPS: failure_strain_pair  <= wr_data;
        REG_FACTORS:  increase_factors     <= wr_data[31:0];
        REG_OPTIONS:  option_flags         <= wr_data[1:0];
        default: ;
      endcase
    end
  end

  rsfs_front u_front (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (start && !busy),
    .strain               (strain),
    .modulus_pair         (modulus_pair),
    .yield_stress_pair    (yield_stress_pair),
    .plateau_strain_pair  (plateau_strain_pair),
    .ultimate_stress_pair (ultimate_stress_pair),
    .ultimate_strain_pair (ultimate_strain_pair),
    .failure_strain_pair  (failure_strain_pair),
    .hard_en              (option_flags[0]),
    .out_valid            (dv[0]),
    .out_item             (di[0])
  );

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    rsfs_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv[k]),
      .in_item   (di[k]),
      .out_valid (dv[k+1]),
      .out_item  (di[k+1])
    );
  end

  rsfs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (dv[DIV_STAGES]),
    .in_item    (di[DIV_STAGES]),
    .fac_en     (option_flags[1]),
    .factors    (increase_factors),
    .done       (done),
    .stress     (stress),
    .region     (region),
    .yielded    (yielded),
    .at_maximum (at_maximum)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/rsfs_front.sv =====
// Front stages: magnitude, side select, yield test, region and divider pre-step.
`timescale 1ns / 1ps
`default_nettype none
module rsfs_front
  import rsfs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic [31:0] strain,
  input  wire logic [63:0] modulus_pair,
  input  wire logic [63:0] yield_stress_pair,
  input  wire logic [63:0] plateau_strain_pair,
  input  wire logic [63:0] ultimate_stress_pair,
  input  wire logic [63:0] ultimate_strain_pair,
  input  wire logic [63:0] failure_strain_pair,
  input  wire logic        hard_en,
  output logic             out_valid,
  output pipe_t            out_item
);

  logic        v1, neg1, zero1;
  logic [31:0] m1, e1, fy1, esh1, fu1, eu1, ef1;

  logic        v2, neg2, zero2, ehz2, lt_esh2, lt_eu2, ge_ef2;
  logic [31:0] fy2, fu2, a2, d2;
  logic [63:0] prod_y2, prod_e2;

  logic        neg_in, comp_in;
  logic [31:0] m_in;

  logic        yld3;
  logic [2:0]  region3;
  logic [35:0] mag3;

  assign neg_in  = strain[31];
  assign comp_in = neg_in || (strain == 32'd0);
  assign m_in    = neg_in ? (~strain + 32'd1) : strain;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    neg1  <= neg_in;
    zero1 <= (strain == 32'd0);
    m1    <= m_in;
    e1    <= comp_in ? modulus_pair[63:32]         : modulus_pair[31:0];
    fy1   <= comp_in ? yield_stress_pair[63:32]    : yield_stress_pair[31:0];
    esh1  <= comp_in ? plateau_strain_pair[63:32]  : plateau_strain_pair[31:0];
    fu1   <= comp_in ? ultimate_stress_pair[63:32] : ultimate_stress_pair[31:0];
    eu1   <= comp_in ? ultimate_strain_pair[63:32] : ultimate_strain_pair[31:0];
    ef1   <= comp_in ? failure_strain_pair[63:32]  : failure_strain_pair[31:0];
  end

  always_ff @(posedge clk) begin
    neg2    <= neg1;
    zero2   <= zero1;
    ehz2    <= (e1 == 32'd0);
    prod_y2 <= 64'(m1 + 32'd1) * 64'(e1);
    prod_e2 <= 64'(m1) * 64'(e1);
    lt_esh2 <= m1 < esh1;
    lt_eu2  <= m1 < eu1;
    ge_ef2  <= m1 >= ef1;
    a2      <= eu1 - m1;
    d2      <= eu1 - esh1;
    fy2     <= fy1;
    fu2     <= fu1;
  end

  always_comb begin
    yld3 = !ehz2 && (prod_y2 > {4'd0, fy2, 28'd0});
    if (zero2) begin
      region3 = REGION_ZERO;
    end else if (!yld3) begin
      region3 = REGION_ELASTIC;
    end else if (lt_esh2) begin
      region3 = REGION_PLATEAU;
    end else if (lt_eu2) begin
      region3 = hard_en ? REGION_HARDEN : REGION_PLATEAU;
    end else begin
      region3 = REGION_FAILED;
    end
    case (region3)
      REGION_ELASTIC: mag3 = prod_e2[63:28];
      REGION_PLATEAU: mag3 = {4'd0, fy2};
      default:        mag3 = 36'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    out_item.neg      <= neg2;
    out_item.region   <= region3;
    out_item.yielded  <= yld3;
    out_item.at_max   <= ge_ef2;
    out_item.base_mag <= mag3;
    out_item.dl       <= (fu2 >= fy2) ? (fu2 - fy2) : (fy2 - fu2);
    out_item.fu       <= fu2;
    out_item.fu_ge    <= fu2 >= fy2;
    out_item.q_hi     <= a2 >= d2;
    out_item.rem      <= (a2 >= d2) ? (a2 - d2) : a2;
    out_item.d        <= d2;
    out_item.quo      <= 32'd0;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rsfs_div_stage.sv =====
// One divider stage: DIV_STEPS restoring steps of the hardening ratio.
`timescale 1ns / 1ps
`default_nettype none
module rsfs_div_stage
  import rsfs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire pipe_t in_item,
  output logic       out_valid,
  output pipe_t      out_item
);

  pipe_t       nxt;
  logic [32:0] r2;
  logic [31:0] r;
  logic [31:0] q;

  always_comb begin
    r = in_item.rem;
    q = in_item.quo;
    r2 = 33'd0;
    for (int j = 0; j < DIV_STEPS; j++) begin
      r2 = {r, 1'b0};
      if (r2 >= {1'b0, in_item.d}) begin
        r2 = r2 - {1'b0, in_item.d};
        q = {q[30:0], 1'b1};
      end else begin
        q = {q[30:0], 1'b0};
      end
      r = r2[31:0];
    end
    nxt = in_item;
    nxt.rem = r;
    nxt.quo = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_item <= nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rsfs_back.sv =====
// Back stages: parabola terms, increase factor and saturated signed result.
`timescale 1ns / 1ps
`default_nettype none
module rsfs_back
  import rsfs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire pipe_t       in_item,
  input  wire logic        fac_en,
  input  wire logic [31:0] factors,
  output logic             done,
  output logic [31:0]      stress,
  output logic [2:0]       region,
  output logic             yielded,
  output logic             at_maximum
);

  logic        v1, v2, v3, v4;
  pipe_t       p1, p2, p3, p4;
  logic [31:0] q0, q2, t;
  logic [63:0] qq, dq;
  logic [35:0] mag3;
  logic [15:0] fac3;
  logic [32:0] s;
  logic [51:0] prod4;
  logic [39:0] scaled;
  logic [31:0] cap;

  assign q0 = {in_item.q_hi, 31'd0} | {1'b0, in_item.quo[31:1]};
  assign qq = 64'(q0) * 64'(q0);
  assign dq = 64'(p1.dl) * 64'(q2);
  assign s  = p2.fu_ge ? ({1'b0, p2.fu} - {1'b0, t}) : ({1'b0, p2.fu} + {1'b0, t});
  assign scaled = prod4[51:12];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      done <= v4;
    end
  end

  always_ff @(posedge clk) begin
    p1 <= in_item;
    q2 <= qq[62:31];
    p2 <= p1;
    t  <= dq[62:31];
    p3 <= p2;
    mag3 <= (p2.region == REGION_HARDEN) ? {3'd0, s} : p2.base_mag;
    fac3 <= !fac_en ? FACTOR_UNITY :
            (p2.region == REGION_HARDEN) ? factors[31:16] : factors[15:0];
    p4 <= p3;
    prod4 <= 52'(mag3) * 52'(fac3);
  end

  always_comb begin
    if (p4.neg) begin
      cap = (scaled > 40'h0080000000) ? 32'h8000_0000 : scaled[31:0];
    end else begin
      cap = (scaled > 40'h007FFFFFFF) ? 32'h7FFF_FFFF : scaled[31:0];
    end
  end

  always_ff @(posedge clk) begin
    stress     <= p4.neg ? (~cap + 32'd1) : cap;
    region     <= p4.region;
    yielded    <= p4.yielded;
    at_maximum <= p4.at_max;
  end

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for the rebar stress-from-strain core: directed table plus random strains.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import rsfs_pkg::*;

  typedef struct {
    logic [31:0] stress;
    logic [2:0]  region;
    logic        yielded;
    logic        at_max;
  } stress_word_t;

  typedef struct {
    logic [31:0] strain;
    logic        typed;
    logic [31:0] stress;
    logic [2:0]  region;
  } strain_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [31:0] strain = '0;
  logic        wr_en = 1'b0;
  logic [2:0]  wr_index = '0;
  logic [63:0] wr_data = '0;
  logic        busy, done, yielded, at_maximum;
  logic [31:0] stress;
  logic [2:0]  region;

  logic [63:0] mod_r, fy_r, esh_r, fu_r, eu_r, ef_r;
  logic [31:0] fac_r;
  logic [1:0]  opt_r;

  stress_word_t pending_stress[$];
  int          n_errors = 0;

  rebar_stress_from_strain_core i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #200ms;
    $display("tb_top: errors");
    $finish;
  end

  function automatic logic [63:0] scale_by_factor(logic [63:0] s, logic [63:0] f);
    logic [63:0] c;
    if (!opt_r[1]) return s;
    c = (s > 64'hFF_FFFF_FFFF) ? 64'hFF_FFFF_FFFF : s;
    return (c * f) >> 12;
  endfunction

  function automatic stress_word_t stress_of_strain(logic [31:0] raw);
    stress_word_t r;
    logic neg, comp, has_ey;
    logic [63:0] m, e, fy, esh, fu, eu, ef, ey, mag, d, a, q, q2, dl, t, s;
    neg = raw[31];
    comp = neg || raw == 0;
    m = neg ? (64'h1_0000_0000 - {32'd0, raw}) : {32'd0, raw};
    e = comp ? mod_r[63:32] : mod_r[31:0];
    fy = comp ? fy_r[63:32] : fy_r[31:0];
    esh = comp ? esh_r[63:32] : esh_r[31:0];
    fu = comp ? fu_r[63:32] : fu_r[31:0];
    eu = comp ? eu_r[63:32] : eu_r[31:0];
    ef = comp ? ef_r[63:32] : ef_r[31:0];
    has_ey = e != 0;
    ey = has_ey ? ((fy << 28) / e) : 0;
    mag = 0;
    if (raw == 0) begin
      r.region = REGION_ZERO;
    end else if (!has_ey || m < ey) begin
      r.region = REGION_ELASTIC;
      mag = scale_by_factor((e * m) >> 28, fac_r[15:0]);
    end else if (m < esh) begin
      r.region = REGION_PLATEAU;
      mag = scale_by_factor(fy, fac_r[15:0]);
    end else if (m < eu) begin
      if (opt_r[0]) begin
        d = eu - esh;
        a = eu - m;
        q = (a << 31) / d;
        q2 = (q * q) >> 31;
        dl = fu >= fy ? fu - fy : fy - fu;
        t = (dl * q2) >> 31;
        s = fu >= fy ? fu - t : fu + t;
        r.region = REGION_HARDEN;
        mag = scale_by_factor(s, fac_r[31:16]);
      end else begin
        r.region = REGION_PLATEAU;
        mag = scale_by_factor(fy, fac_r[15:0]);
      end
    end else begin
      r.region = REGION_FAILED;
    end
    if (neg) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      r.stress = 32'(64'h1_0000_0000 - mag);
    end else begin
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      r.stress = mag[31:0];
    end
    r.yielded = has_ey && m >= ey;
    r.at_max = m >= ef;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    n_errors++;
  endtask

  always @(posedge clk) begin
    stress_word_t w;
    if (!rst && done) begin
      if (pending_stress.size() == 0) begin
        report_mismatch("unexpected word", stress, 32'd0);
      end else begin
        w = pending_stress.pop_front();
        if (stress !== w.stress) report_mismatch("stress", stress, w.stress);
        if (region !== w.region) report_mismatch("region", 32'(region), 32'(w.region));
        if (yielded !== w.yielded)
          report_mismatch("yielded", 32'(yielded), 32'(w.yielded));
        if (at_maximum !== w.at_max)
          report_mismatch("at_maximum", 32'(at_maximum), 32'(w.at_max));
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    case (idx)
      REG_MODULUS:  mod_r = val;
      REG_YIELD:    fy_r = val;
      REG_PLATEAU:  esh_r = val;
      REG_ULT_STR:  fu_r = val;
      REG_ULT_EPS:  eu_r = val;
      REG_FAIL_EPS: ef_r = val;
      REG_FACTORS:  fac_r = val[31:0];
      default:      opt_r = val[1:0];
    endcase
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_stress.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic send_strain(logic [31:0] s, logic gaps);
    int g;
    @(negedge clk);
    if (gaps && $urandom_range(0, 2) == 0) begin
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (g) @(negedge clk);
    end
    start <= 1'b1;
    strain <= s;
    pending_stress.push_back(stress_of_strain(s));
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic stop_strain();
    @(negedge clk);
    start <= 1'b0;
  endtask

  function automatic logic [31:0] pick_strain(logic [63:0] esh, logic [63:0] eu);
    logic [31:0] mg;
    case ($urandom_range(0, 5))
      0: mg = $urandom;
      1: mg = $urandom_range(0, 32'h0100_0000);
      2: mg = esh[31:0] + $urandom_range(0, 4) - 2;
      3: mg = eu[31:0] + $urandom_range(0, 4) - 2;
      default: mg = $urandom_range(esh[31:0], eu[31:0]);
    endcase
    return $urandom_range(0, 1) ? -mg : mg;
  endfunction

  task automatic steel_setting(logic extreme);
    logic [31:0] lo, hi;
    for (int i = 0; i < 2; i++) begin
      if (extreme) begin
        mod_r[i*32 +: 32] = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
        fy_r[i*32 +: 32] = $urandom;
        fu_r[i*32 +: 32] = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
        lo = $urandom;
        hi = $urandom;
      end else begin
        mod_r[i*32 +: 32] = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(32'h1000_0000, 32'h3300_0000);
        fy_r[i*32 +: 32] = $urandom_range(32'h0003_0000, 32'h0008_0000);
        fu_r[i*32 +: 32] = $urandom_range(32'h0003_0000, 32'h000A_0000);
        lo = $urandom_range(32'h0008_0000, 32'h0400_0000);
        hi = lo + $urandom_range(1, 32'h0800_0000);
      end
      if (lo > hi) begin
        esh_r[i*32 +: 32] = hi;
        eu_r[i*32 +: 32] = lo;
      end else begin
        esh_r[i*32 +: 32] = lo;
        eu_r[i*32 +: 32] = hi;
      end
      ef_r[i*32 +: 32] = $urandom_range(0, 3) == 0 ? $urandom : eu_r[i*32 +: 32];
    end
    write_reg(REG_MODULUS, mod_r);
    write_reg(REG_YIELD, fy_r);
    write_reg(REG_PLATEAU, esh_r);
    write_reg(REG_ULT_STR, fu_r);
    write_reg(REG_ULT_EPS, eu_r);
    write_reg(REG_FAIL_EPS, ef_r);
    write_reg(REG_FACTORS, extreme ? {$urandom} : {16'($urandom_range(32'h0C00, 32'h2000)),
                                                   16'($urandom_range(32'h0C00, 32'h2000))});
    write_reg(REG_OPTIONS, 64'($urandom_range(0, 3)));
  endtask

  strain_row_t directed_rows[$];

  initial begin
    mod_r = '0; fy_r = '0; esh_r = '0; fu_r = '0; eu_r = '0; ef_r = '0;
    fac_r = FACTORS_RESET;
    opt_r = OPTIONS_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // after reset every nonzero strain is elastic with zero modulus
    directed_rows = '{
      '{32'h0000_0000, 1, 32'h0, REGION_ZERO},
      '{32'h7FFF_FFFF, 1, 32'h0, REGION_ELASTIC},
      '{32'h8000_0000, 1, 32'h0, REGION_ELASTIC},
      '{32'h0000_0001, 1, 32'h0, REGION_ELASTIC},
      '{32'hFFFF_FFFF, 1, 32'h0, REGION_ELASTIC}};
    foreach (directed_rows[k]) begin
      send_strain(directed_rows[k].strain, 1'b0);
      if (directed_rows[k].typed) begin
        pending_stress[$].stress = directed_rows[k].stress;
        pending_stress[$].region = directed_rows[k].region;
      end
    end
    stop_strain();
    wait_drained();

    // typical steel: 200 GPa-ish ratios, hardening on
    write_reg(REG_MODULUS, {32'h2000_0000, 32'h2000_0000});
    write_reg(REG_YIELD, {32'h0004_0000, 32'h0004_0000});
    write_reg(REG_PLATEAU, {32'h0100_0000, 32'h0080_0000});
    write_reg(REG_ULT_STR, {32'h0006_0000, 32'h0003_0000});
    write_reg(REG_ULT_EPS, {32'h0400_0000, 32'h0200_0000});
    write_reg(REG_FAIL_EPS, {32'h0300_0000, 32'h0400_0000});
    write_reg(REG_FACTORS, 64'h1400_1200);
    write_reg(REG_OPTIONS, 64'd1);
    directed_rows = '{
      '{32'h0000_0000, 1, 32'h0, REGION_ZERO},
      '{32'h0000_1000, 0, 0, 0}, '{32'h0002_0000, 0, 0, 0},
      '{32'h0008_0000, 0, 0, 0}, '{32'h00FF_FFFF, 0, 0, 0},
      '{32'h0100_0000, 0, 0, 0}, '{32'h0250_0000, 0, 0, 0},
      '{32'h03FF_FFFF, 0, 0, 0},
      '{32'h0400_0000, 1, 32'h0, REGION_FAILED},
      '{32'h7FFF_FFFF, 1, 32'h0, REGION_FAILED},
      '{32'h8000_0000, 1, 32'h0, REGION_FAILED},
      '{32'hFF80_0000, 0, 0, 0}, '{32'hFF00_0000, 0, 0, 0},
      '{32'hFFFF_F000, 0, 0, 0}};
    foreach (directed_rows[k]) begin
      send_strain(directed_rows[k].strain, 1'b0);
      if (directed_rows[k].typed) begin
        pending_stress[$].stress = directed_rows[k].stress;
        pending_stress[$].region = directed_rows[k].region;
      end
    end
    stop_strain();
    wait_drained();
    write_reg(REG_OPTIONS, 64'd2);
    send_strain(32'h0250_0000, 1'b0);
    send_strain(32'hFE00_0001, 1'b0);
    stop_strain();
    wait_drained();

    for (int ph = 0; ph < 12; ph++) begin
      steel_setting(ph % 4 == 3);
      for (int n = 0; n < 150; n++)
        send_strain(pick_strain(n[0] ? esh_r[63:32] : esh_r[31:0],
                                n[0] ? eu_r[63:32] : eu_r[31:0]), ph % 3 != 0);
      stop_strain();
      wait_drained();
    end

    // saturation corners: all ones in modulus, yield and factors
    write_reg(REG_MODULUS, '1);
    write_reg(REG_YIELD, '1);
    write_reg(REG_FACTORS, 64'hFFFF_FFFF);
    write_reg(REG_OPTIONS, 64'd3);
    send_strain(32'h7FFF_FFFF, 1'b0);
    send_strain(32'h8000_0000, 1'b0);
    send_strain(32'h0000_0001, 1'b0);
    stop_strain();
    wait_drained();

    if (n_errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
hw/rtl/rsfs_pkg.sv
hw/rtl/rsfs_front.sv
hw/rtl/rsfs_div_stage.sv
hw/rtl/rsfs_back.sv
hw/rtl/rebar_stress_from_strain_core.sv
test/tb_top.sv
